// ----- rtl/projected_nearest_in_radius_select_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_NEAREST_IN_RADIUS_SELECT_CORE_ASSERT_SVH
`define PROJECTED_NEAREST_IN_RADIUS_SELECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PNIS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
	else $error("assertion failed");
`define PNIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define PNIS_ASSERT(lbl, clk, rstn, prop)
`define PNIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/pnis_pkg.sv -----
// ----------------------------------------------------------------------------
// pnis_pkg
// Shared widths and types of the projected nearest point selector.
// ----------------------------------------------------------------------------
package pnis_pkg;
	localparam int NDC_BITS = 40;
	localparam int MUL_W    = 34;
	localparam int PROD_W   = 2 * MUL_W;

	localparam logic [2:0] REG_ROW_X_LO = 3'd0;
	localparam logic [2:0] REG_ROW_X_HI = 3'd1;
	localparam logic [2:0] REG_ROW_Y_LO = 3'd2;
	localparam logic [2:0] REG_ROW_Y_HI = 3'd3;
	localparam logic [2:0] REG_ROW_W_LO = 3'd4;
	localparam logic [2:0] REG_ROW_W_HI = 3'd5;
	localparam logic [2:0] REG_VIEW     = 3'd6;
	localparam logic [2:0] REG_VIEWER   = 3'd7;

	typedef struct packed {
		logic busy;
		logic done;
	} pnis_div_stat_t;
endpackage

// ----- rtl/pnis_mul.sv -----
// ----------------------------------------------------------------------------
// pnis_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pnis_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pnis_pkg::MUL_W-1:0]    a,
	input  logic signed [pnis_pkg::MUL_W-1:0]    b,
	output logic signed [pnis_pkg::PROD_W-1:0]   prod,
	output logic                                 done
);
	import pnis_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic                     done_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	assign prod = prod_q;
	assign done = done_q;
endmodule

// ----- rtl/pnis_div.sv -----
// ----------------------------------------------------------------------------
// pnis_div
// Restoring divider: num * 2^F / den, truncated, saturated to NDC_BITS.
// ----------------------------------------------------------------------------
module pnis_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [63:0]                     num,
	input  logic [63:0]                     den,
	output logic [pnis_pkg::NDC_BITS-1:0]   quo,
	output pnis_pkg::pnis_div_stat_t        stat
);
	import pnis_pkg::*;

	localparam int SH    = NDC_BITS - FRAC_BITS;
	localparam int CNT_W = $clog2(NDC_BITS + 1);

	logic [63:0]         rem_q;
	logic [63:0]         den_q;
	logic [NDC_BITS-1:0] sh_q;
	logic                sat_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [64:0]         trial;
	logic                ge;

	assign trial = {rem_q, sh_q[NDC_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= {32'd0, num} >= ({32'd0, den} << SH);
			rem_q <= num >> SH;
			sh_q  <= NDC_BITS'(num << FRAC_BITS);
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			sh_q  <= {sh_q[NDC_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo       = sat_q ? '1 : sh_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ----- rtl/projected_nearest_in_radius_select_core.sv -----
// ----------------------------------------------------------------------------
// projected_nearest_in_radius_select_core
// Projects points, keeps those in the screen radius, selects the nearest.
// ----------------------------------------------------------------------------
// A present point that passes every test needs nine clip products, two
// 40-step divisions and seven more products, each product on the shared
// multiplier. An absent point skips to S_DONE. One item is in work at a time.
// The result register frees the output side; it is written on the last item.
// Reset clears registers and search state asynchronously.
`include "projected_nearest_in_radius_select_core_assert.svh"
module projected_nearest_in_radius_select_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,   // point_x, point_y, point_z
	input  logic [0:0]    s_tuser,   // present
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [159:0]  m_tdata,   // best_x, best_y, best_z, best_dist_sq
	output logic [0:0]    m_tuser,   // found
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [63:0]   cfg_wdata
);
	import pnis_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_ACC  = 4'd2;
	localparam logic [3:0] S_WCHK = 4'd3;
	localparam logic [3:0] S_DIVX = 4'd4;
	localparam logic [3:0] S_DIVY = 4'd5;
	localparam logic [3:0] S_RCHK = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;

	localparam logic [2:0] OP_CLIP = 3'd0;
	localparam logic [2:0] OP_OX   = 3'd1;
	localparam logic [2:0] OP_OY   = 3'd2;
	localparam logic [2:0] OP_SQX  = 3'd3;
	localparam logic [2:0] OP_SQY  = 3'd4;
	localparam logic [2:0] OP_LIM  = 3'd5;
	localparam logic [2:0] OP_DX   = 3'd6;
	localparam logic [2:0] OP_DZ   = 3'd7;

	localparam logic signed [63:0] W_MIN = 64'(((64'sd1 <<< FRAC_BITS) + 5) / 10);
	localparam logic [62:0] DIST_RESET = 63'(64'd9999800001 << FRAC_BITS);

	logic [63:0]              regs_q [8];
	logic [3:0]               state_q;
	logic [2:0]               op_q;
	logic [1:0]               row_q, col_q;
	logic signed [31:0]       x_q, y_q, z_q;
	logic                     last_q;
	logic signed [63:0]       acc_q [3];
	logic [NDC_BITS-1:0]      ndcx_q, ndcy_q;
	logic [48:0]              ox_q, oy_q;
	logic [66:0]              sq_q;
	logic [62:0]              near_d_q;
	logic [31:0]              near_x_q, near_y_q, near_z_q;
	logic                     have_q;
	logic                     m_tvalid_q;
	logic [159:0]             m_tdata_q;
	logic                     m_found_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     mul_done;
	logic                     mul_start;
	logic                     div_start;
	logic [63:0]              div_num;
	logic [NDC_BITS-1:0]      div_q;
	pnis_div_stat_t           div_stat;

	logic [15:0]              width, height;
	logic signed [31:0]       rad, vx, vz;
	logic [32:0]              lim;
	logic signed [32:0]       dx, dz;
	logic [32:0]              dx_mag, dz_mag;
	logic [63:0]              mag_cx, mag_cy;
	logic                     w_low, big, out_free, emit;
	logic [66:0]              dsum;
	logic [62:0]              cand_d;
	logic [65:0]              prod_u;

	assign width   = regs_q[REG_VIEW][15:0];
	assign height  = regs_q[REG_VIEW][31:16];
	assign rad     = regs_q[REG_VIEW][63:32];
	assign vx      = regs_q[REG_VIEWER][31:0];
	assign vz      = regs_q[REG_VIEWER][63:32];
	assign lim     = {rad, 1'b0};
	assign dx      = $signed({x_q[31], x_q}) - $signed({vx[31], vx});
	assign dz      = $signed({z_q[31], z_q}) - $signed({vz[31], vz});
	assign dx_mag  = dx[32] ? 33'(-dx) : dx;
	assign dz_mag  = dz[32] ? 33'(-dz) : dz;
	assign mag_cx  = acc_q[0][63] ? 64'(-acc_q[0]) : acc_q[0];
	assign mag_cy  = acc_q[1][63] ? 64'(-acc_q[1]) : acc_q[1];
	assign w_low   = acc_q[2] < W_MIN;
	assign big     = (width != 16'd0 && ndcx_q[NDC_BITS-1:33] != '0)
	              || (height != 16'd0 && ndcy_q[NDC_BITS-1:33] != '0);
	assign prod_u  = prod[65:0];
	assign dsum    = sq_q + {1'b0, prod_u};
	assign cand_d  = 63'(dsum >> FRAC_BITS);
	assign out_free = !m_tvalid_q || m_tready;
	assign emit    = state_q == S_DONE && last_q && out_free;

	assign mul_start = state_q == S_MUL;
	assign div_start = (state_q == S_WCHK && !w_low) || (state_q == S_DIVX && div_stat.done);
	assign div_num   = (state_q == S_WCHK) ? mag_cx : mag_cy;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op_q)
			OP_CLIP: begin
				unique case (col_q)
					2'd0:    mul_a = MUL_W'(x_q);
					2'd1:    mul_a = MUL_W'(y_q);
					default: mul_a = MUL_W'(z_q);
				endcase
				unique case ({row_q, col_q})
					4'b0000: mul_b = MUL_W'($signed(regs_q[REG_ROW_X_LO][31:0]));
					4'b0001: mul_b = MUL_W'($signed(regs_q[REG_ROW_X_LO][63:32]));
					4'b0010: mul_b = MUL_W'($signed(regs_q[REG_ROW_X_HI][31:0]));
					4'b0100: mul_b = MUL_W'($signed(regs_q[REG_ROW_Y_LO][31:0]));
					4'b0101: mul_b = MUL_W'($signed(regs_q[REG_ROW_Y_LO][63:32]));
					4'b0110: mul_b = MUL_W'($signed(regs_q[REG_ROW_Y_HI][31:0]));
					4'b1000: mul_b = MUL_W'($signed(regs_q[REG_ROW_W_LO][31:0]));
					4'b1001: mul_b = MUL_W'($signed(regs_q[REG_ROW_W_LO][63:32]));
					4'b1010: mul_b = MUL_W'($signed(regs_q[REG_ROW_W_HI][31:0]));
					default: mul_b = '0;
				endcase
			end
			OP_OX: begin
				mul_a = {18'd0, width};
				mul_b = {1'b0, ndcx_q[32:0]};
			end
			OP_OY: begin
				mul_a = {18'd0, height};
				mul_b = {1'b0, ndcy_q[32:0]};
			end
			OP_SQX: begin
				mul_a = {1'b0, ox_q[32:0]};
				mul_b = {1'b0, ox_q[32:0]};
			end
			OP_SQY: begin
				mul_a = {1'b0, oy_q[32:0]};
				mul_b = {1'b0, oy_q[32:0]};
			end
			OP_LIM: begin
				mul_a = {1'b0, lim};
				mul_b = {1'b0, lim};
			end
			OP_DX: begin
				mul_a = {1'b0, dx_mag};
				mul_b = {1'b0, dx_mag};
			end
			OP_DZ: begin
				mul_a = {1'b0, dz_mag};
				mul_b = {1'b0, dz_mag};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pnis_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	pnis_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (acc_q[2]),
		.quo    (div_q),
		.stat   (div_stat)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			x_q      <= s_tdata[31:0];
			y_q      <= s_tdata[63:32];
			z_q      <= s_tdata[95:64];
			acc_q[0] <= 64'($signed(regs_q[REG_ROW_X_HI][63:32]));
			acc_q[1] <= 64'($signed(regs_q[REG_ROW_Y_HI][63:32]));
			acc_q[2] <= 64'($signed(regs_q[REG_ROW_W_HI][63:32]));
		end
		if (state_q == S_ACC && op_q == OP_CLIP) begin
			acc_q[row_q] <= acc_q[row_q] + 64'(prod >>> FRAC_BITS);
		end
		if (state_q == S_DIVX && div_stat.done) begin
			ndcx_q <= div_q;
		end
		if (state_q == S_DIVY && div_stat.done) begin
			ndcy_q <= div_q;
		end
		if (state_q == S_ACC) begin
			unique case (op_q)
				OP_OX:   ox_q <= prod[48:0];
				OP_OY:   oy_q <= prod[48:0];
				OP_SQX:  sq_q <= {1'b0, prod_u};
				OP_SQY:  sq_q <= dsum;
				OP_DX:   sq_q <= {1'b0, prod_u};
				default: sq_q <= sq_q;
			endcase
		end
		if (emit) begin
			m_found_q <= have_q;
			m_tdata_q <= have_q ? {1'b0, near_d_q, near_z_q, near_y_q, near_x_q} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= '0;
			end
			state_q    <= S_IDLE;
			op_q       <= OP_CLIP;
			row_q      <= '0;
			col_q      <= '0;
			last_q     <= 1'b0;
			near_d_q   <= DIST_RESET;
			near_x_q   <= '0;
			near_y_q   <= '0;
			near_z_q   <= '0;
			have_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				regs_q[cfg_addr] <= cfg_wdata;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						last_q  <= s_tlast;
						op_q    <= OP_CLIP;
						row_q   <= '0;
						col_q   <= '0;
						state_q <= s_tuser[0] ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (mul_done) begin
						state_q <= S_MUL;
						unique case (op_q)
							OP_CLIP: begin
								if (col_q == 2'd2) begin
									col_q <= '0;
									row_q <= row_q + 1'b1;
									if (row_q == 2'd2) begin
										state_q <= S_WCHK;
									end
								end else begin
									col_q <= col_q + 1'b1;
								end
							end
							OP_OX:  op_q <= OP_OY;
							OP_OY:  state_q <= S_RCHK;
							OP_SQX: op_q <= OP_SQY;
							OP_SQY: op_q <= OP_LIM;
							OP_LIM: begin
								if (sq_q > {1'b0, prod_u}) begin
									state_q <= S_DONE;
								end else begin
									op_q <= OP_DX;
								end
							end
							OP_DX:  op_q <= OP_DZ;
							OP_DZ: begin
								if (cand_d < near_d_q) begin
									near_d_q <= cand_d;
									near_x_q <= x_q;
									near_y_q <= y_q;
									near_z_q <= z_q;
									have_q   <= 1'b1;
								end
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WCHK: begin
					state_q <= w_low ? S_DONE : S_DIVX;
				end
				S_DIVX: begin
					if (div_stat.done) begin
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_stat.done) begin
						op_q    <= OP_OX;
						state_q <= S_MUL;
					end
				end
				S_RCHK: begin
					if (rad[31] || big || ox_q > 49'(lim) || oy_q > 49'(lim)) begin
						state_q <= S_DONE;
					end else begin
						op_q    <= OP_SQX;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						near_d_q   <= DIST_RESET;
						near_x_q   <= '0;
						near_y_q   <= '0;
						near_z_q   <= '0;
						have_q     <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready   = state_q == S_IDLE;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_found_q;

	`PNIS_ASSERT(a_ready_div_idle, clk, arst_n, s_tready |-> !div_stat.busy)
	`PNIS_ASSERT(a_empty_zero, clk, arst_n, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
	`PNIS_ASSERT(a_div_done_state, clk, arst_n, div_stat.done |-> (state_q == S_DIVX || state_q == S_DIVY))
	`PNIS_ASSERT_NEXT(a_clear_after_emit, clk, arst_n, emit, (!have_q && m_tvalid))
endmodule
